// File: rtl/tiop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tiop_pkg
// Shared types and constants for the telnet receive option parser.
// ----------------------------------------------------------------------------
package tiop_pkg;

	localparam logic [7:0] B_NOP  = 8'd241;
	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_ECHO = 8'd1;
	localparam logic [7:0] B_CR   = 8'd13;
	localparam logic [7:0] B_LF   = 8'd10;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		STG_IDLE = 2'd0,
		STG_CMD  = 2'd1,
		STG_OPT  = 2'd2
	} stage_t;

	// one classified byte, as handed from front to back
	typedef struct packed {
		logic       line_valid;
		logic [6:0] line_char;
		logic       line_end;
		logic       echo_valid;
		logic [7:0] echo_char;
		logic       echo_done;
		logic       link_open;
		logic       echo_on;
		logic       add_lf;
	} item_t;

endpackage
`default_nettype wire

// File: rtl/tiop_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tiop_front
// Accepts payload bytes, runs the option/text state and classifies each byte.
// ----------------------------------------------------------------------------
module tiop_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          packet_end,
	output tiop_pkg::item_t    item
);
	import tiop_pkg::*;

	stage_t     stage_q, stage_n;
	logic [7:0] cmd_q, cmd_n;
	logic       echo_q, echo_n;
	logic       open_q, open_n;
	logic       cr_q, cr_n;
	logic       lf_q, lf_n;
	logic       text_q, text_n;
	logic       add_lf;

	always_comb begin
		stage_n = stage_q;
		cmd_n   = cmd_q;
		echo_n  = echo_q;
		open_n  = open_q;
		text_n  = text_q;
		cr_n    = cr_q;
		lf_n    = lf_q;
		item    = '0;
		add_lf  = 1'b0;

		if (!text_q) begin
			unique case (stage_q)
				STG_CMD: begin
					cmd_n   = data_byte;
					stage_n = (data_byte == B_NOP) ? STG_IDLE : STG_OPT;
				end
				STG_OPT: begin
					stage_n = STG_IDLE;
					if (data_byte == B_ECHO) begin
						if (cmd_q == B_DO)
							echo_n = 1'b1;
						else if (cmd_q == B_DONT)
							echo_n = 1'b0;
					end
				end
				default: begin
					stage_n = STG_IDLE;
					if (data_byte == B_IAC) begin
						stage_n = STG_CMD;
						open_n  = 1'b1;
					end else if (!data_byte[7]) begin
						text_n = 1'b1;
					end
				end
			endcase
		end

		if (text_n) begin
			if (data_byte == B_LF) begin
				lf_n = 1'b1;
			end else if (!data_byte[7] && data_byte != 8'd0) begin
				item.line_valid = 1'b1;
				item.line_char  = data_byte[6:0];
				if (data_byte == B_CR) begin
					item.line_end = 1'b1;
					cr_n          = 1'b1;
				end
			end
			if (echo_n) begin
				item.echo_valid = 1'b1;
				item.echo_char  = data_byte;
				if (packet_end) begin
					add_lf         = cr_n && !lf_n;
					item.echo_done = !add_lf;
				end
			end
		end

		item.link_open = open_n;
		item.echo_on   = echo_n;
		item.add_lf    = add_lf;

		// segment end drops any half-parsed sequence
		if (packet_end) begin
			stage_n = STG_IDLE;
			text_n  = 1'b0;
			cr_n    = 1'b0;
			lf_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STG_IDLE;
			cmd_q   <= '0;
			echo_q  <= 1'b0;
			open_q  <= 1'b0;
			cr_q    <= 1'b0;
			lf_q    <= 1'b0;
			text_q  <= 1'b0;
		end else if (accept) begin
			stage_q <= stage_n;
			cmd_q   <= cmd_n;
			echo_q  <= echo_n;
			open_q  <= open_n;
			cr_q    <= cr_n;
			lf_q    <= lf_n;
			text_q  <= text_n;
		end
	end

endmodule
`default_nettype wire

// File: rtl/tiop_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tiop_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module tiop_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tiop_pkg::item_t push_item,
	input  wire logic          pop,
	output tiop_pkg::item_t    head,
	output logic               full,
	output logic               empty
);
	import tiop_pkg::*;

	item_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q, rd_q;
	logic [Q_CW-1:0]   count_q;

	assign full  = (count_q == Q_CW'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/tiop_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tiop_back
// Drains the queue into the output register; owes an extra LF transaction
// when, with echo on, a segment that had a CR but no LF ends on a text byte.
// ----------------------------------------------------------------------------
module tiop_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tiop_pkg::item_t head,
	input  wire logic          empty,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               line_valid,
	output logic [6:0]         line_char,
	output logic               line_end,
	output logic               echo_valid,
	output logic [7:0]         echo_char,
	output logic               echo_done,
	output logic               link_open,
	output logic               echo_on,
	output logic               run_last
);
	import tiop_pkg::*;

	logic       valid_q;
	logic       pend_lf_q;
	logic       out_free;
	logic       lv_q, le_q, ev_q, ed_q, lo_q, eo_q, last_q;
	logic [6:0] lc_q;
	logic [7:0] ec_q;

	assign out_free = !valid_q || !out_stall;
	assign pop      = out_free && !pend_lf_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pend_lf_q <= 1'b0;
		end else if (out_free) begin
			if (pend_lf_q) begin
				valid_q   <= 1'b1;
				pend_lf_q <= 1'b0;
			end else begin
				valid_q   <= !empty;
				pend_lf_q <= !empty && head.add_lf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_lf_q) begin
				// status fields kept from the byte that caused it
				lv_q   <= 1'b0;
				lc_q   <= '0;
				le_q   <= 1'b0;
				ev_q   <= 1'b1;
				ec_q   <= B_LF;
				ed_q   <= 1'b1;
				last_q <= 1'b1;
			end else if (!empty) begin
				lv_q   <= head.line_valid;
				lc_q   <= head.line_char;
				le_q   <= head.line_end;
				ev_q   <= head.echo_valid;
				ec_q   <= head.echo_char;
				ed_q   <= head.echo_done;
				lo_q   <= head.link_open;
				eo_q   <= head.echo_on;
				last_q <= !head.add_lf;
			end
		end
	end

	assign out_valid  = valid_q;
	assign line_valid = lv_q;
	assign line_char  = lc_q;
	assign line_end   = le_q;
	assign echo_valid = ev_q;
	assign echo_char  = ec_q;
	assign echo_done  = ed_q;
	assign link_open  = lo_q;
	assign echo_on    = eo_q;
	assign run_last   = last_q;

	a_pend_shape: assert property (@(posedge clk) disable iff (!arst_n)
		pend_lf_q |-> (valid_q && !last_q && ev_q))
		else $error("owed LF without a first transaction in the register");

	a_lf_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_stall && !last_q) |=>
		(valid_q && ec_q == B_LF && ed_q && last_q && !lv_q))
		else $error("appended LF did not follow its byte");

	a_no_pop_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_lf_q |-> !pop)
		else $error("queue popped while LF still owed");

	a_end_has_line: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && le_q) |-> (lv_q && lc_q == B_CR[6:0]))
		else $error("line end without CR line byte");

endmodule
`default_nettype wire

// File: rtl/telnet_rx_option_parser.sv
`default_nettype none
// A byte's first result is written into the queue on acceptance, then registered into the output register.
// Throughput: one byte per cycle while the queue is not full (in_stall low); an appended LF adds an output transaction.
// A four-entry queue between the parsing front and the output back absorbs stalls.
// Reset (arst_n low) clears parse state, echo mode, link state, queue and output valid.
// ----------------------------------------------------------------------------
// telnet_rx_option_parser
// Strips telnet option sequences from a received payload and forwards line
// and echo bytes.
// ----------------------------------------------------------------------------
module telnet_rx_option_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       packet_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            line_valid,
	output logic [6:0]      line_char,
	output logic            line_end,
	output logic            echo_valid,
	output logic [7:0]      echo_char,
	output logic            echo_done,
	output logic            link_open,
	output logic            echo_on,
	output logic            run_last
);
	import tiop_pkg::*;

	item_t front_item;
	item_t head;
	logic  full, empty, pop, accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	tiop_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.packet_end (packet_end),
		.item       (front_item)
	);

	tiop_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	tiop_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_valid (line_valid),
		.line_char  (line_char),
		.line_end   (line_end),
		.echo_valid (echo_valid),
		.echo_char  (echo_char),
		.echo_done  (echo_done),
		.link_open  (link_open),
		.echo_on    (echo_on),
		.run_last   (run_last)
	);

endmodule
`default_nettype wire
